### rtl/core/pascal_subset_tokenizer_core_macros.svh
// Assertion macros for the tokenizer core.
`ifndef PASCAL_SUBSET_TOKENIZER_CORE_MACROS_SVH
`define PASCAL_SUBSET_TOKENIZER_CORE_MACROS_SVH

// Same-cycle implication.
`define PST_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pst: implication failed");

// Next-cycle implication.
`define PST_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pst: next-cycle implication failed");

`endif

### rtl/core/pst_pkg.sv
package pst_pkg;

  localparam int MAX_TEXT = 32;
  localparam int LEN_W    = $clog2(MAX_TEXT + 1);
  localparam int TIDX_W   = $clog2(MAX_TEXT);
  localparam int KIND_W   = 5;
  localparam int LINE_W   = 24;
  localparam int COL_W    = 16;
  localparam int NUM_W    = 31;
  localparam int BYTE_W   = 8;

  localparam logic [LINE_W-1:0] LINE_MAX = '1;
  localparam logic [COL_W-1:0]  COL_MAX  = '1;
  localparam logic [NUM_W-1:0]  NUM_MAX  = '1;

  localparam logic [KIND_W-1:0] K_INT     = 5'd0;
  localparam logic [KIND_W-1:0] K_IDENT   = 5'd1;
  localparam logic [KIND_W-1:0] K_STRING  = 5'd2;
  localparam logic [KIND_W-1:0] K_BEGIN   = 5'd3;
  localparam logic [KIND_W-1:0] K_END     = 5'd4;
  localparam logic [KIND_W-1:0] K_PROGRAM = 5'd5;
  localparam logic [KIND_W-1:0] K_ASSIGN  = 5'd6;
  localparam logic [KIND_W-1:0] K_LE      = 5'd7;
  localparam logic [KIND_W-1:0] K_GE      = 5'd8;
  localparam logic [KIND_W-1:0] K_NE      = 5'd9;
  localparam logic [KIND_W-1:0] K_RANGE   = 5'd10;
  localparam logic [KIND_W-1:0] K_PLUS    = 5'd11;
  localparam logic [KIND_W-1:0] K_MINUS   = 5'd12;
  localparam logic [KIND_W-1:0] K_SLASH   = 5'd13;
  localparam logic [KIND_W-1:0] K_STAR    = 5'd14;
  localparam logic [KIND_W-1:0] K_LT      = 5'd15;
  localparam logic [KIND_W-1:0] K_GT      = 5'd16;
  localparam logic [KIND_W-1:0] K_LPAREN  = 5'd17;
  localparam logic [KIND_W-1:0] K_RPAREN  = 5'd18;
  localparam logic [KIND_W-1:0] K_LBRACK  = 5'd19;
  localparam logic [KIND_W-1:0] K_RBRACK  = 5'd20;
  localparam logic [KIND_W-1:0] K_COMMA   = 5'd21;
  localparam logic [KIND_W-1:0] K_COLON   = 5'd22;
  localparam logic [KIND_W-1:0] K_SEMI    = 5'd23;
  localparam logic [KIND_W-1:0] K_AT      = 5'd24;
  localparam logic [KIND_W-1:0] K_CARET   = 5'd25;
  localparam logic [KIND_W-1:0] K_EOF     = 5'd26;
  localparam logic [KIND_W-1:0] K_E_STR   = 5'd27;
  localparam logic [KIND_W-1:0] K_E_LF    = 5'd28;
  localparam logic [KIND_W-1:0] K_E_CMT   = 5'd29;
  localparam logic [KIND_W-1:0] K_E_STRAY = 5'd30;
  localparam logic [KIND_W-1:0] K_E_LONG  = 5'd31;
  localparam logic [KIND_W-1:0] OP_NONE   = 5'd0;

  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h27;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_DOT    = 8'h2E;

  localparam logic [7:0] KW_BEGIN [0:4] = '{8'h62, 8'h65, 8'h67, 8'h69, 8'h6E};
  localparam logic [7:0] KW_END   [0:2] = '{8'h65, 8'h6E, 8'h64};
  localparam logic [7:0] KW_PROG  [0:6] =
    '{8'h70, 8'h72, 8'h6F, 8'h67, 8'h72, 8'h61, 8'h6D};

  typedef enum logic [2:0] {
    M_IDLE, M_NUMBER, M_IDENT, M_STRING, M_BRACE, M_PAREN, M_PSTAR, M_OP
  } lex_mode_t;

  typedef enum logic [1:0] {P_NONE, P_ONE, P_TEXT} pre_plan_t;

  typedef enum logic [1:0] {SEL_PRE, SEL_TXT, SEL_POST} out_sel_t;

  typedef enum logic [2:0] {
    C_READY, C_DISPATCH, C_PRE, C_TXT_RD, C_TXT_OUT, C_POST
  } ctl_state_t;

  typedef struct packed {
    logic      accept;
    logic      load;
    out_sel_t  sel;
    logic      last;
    logic      adv;
  } pst_cmd_t;

  typedef struct packed {
    pre_plan_t pre;
    logic      post;
    logic      idx_last;
    logic      out_free;
    logic      halted;
  } pst_sts_t;

  function automatic logic is_digit(logic [7:0] b);
    return (b >= 8'h30) && (b <= 8'h39);
  endfunction

  function automatic logic is_alpha(logic [7:0] b);
    return (b == 8'h5F) || ((b >= 8'h61) && (b <= 8'h7A)) || ((b >= 8'h41) && (b <= 8'h5A));
  endfunction

  function automatic logic [7:0] to_lower(logic [7:0] b);
    return ((b >= 8'h41) && (b <= 8'h5A)) ? b + 8'd32 : b;
  endfunction

  function automatic logic [KIND_W-1:0] single_op(logic [7:0] b);
    logic [KIND_W-1:0] k;
    unique case (b)
      8'h2B:   k = K_PLUS;
      8'h2D:   k = K_MINUS;
      8'h2F:   k = K_SLASH;
      8'h2A:   k = K_STAR;
      8'h3C:   k = K_LT;
      8'h3E:   k = K_GT;
      8'h28:   k = K_LPAREN;
      8'h29:   k = K_RPAREN;
      8'h5B:   k = K_LBRACK;
      8'h5D:   k = K_RBRACK;
      8'h2C:   k = K_COMMA;
      8'h3A:   k = K_COLON;
      8'h3B:   k = K_SEMI;
      8'h40:   k = K_AT;
      8'h5E:   k = K_CARET;
      default: k = OP_NONE;
    endcase
    return k;
  endfunction

  function automatic logic [KIND_W-1:0] double_op(logic [7:0] a, logic [7:0] b);
    logic [KIND_W-1:0] k;
    k = OP_NONE;
    if (a == CH_COLON && b == CH_EQ) k = K_ASSIGN;
    else if (a == CH_LT && b == CH_EQ) k = K_LE;
    else if (a == CH_GT && b == CH_EQ) k = K_GE;
    else if (a == CH_LT && b == CH_GT) k = K_NE;
    else if (a == CH_DOT && b == CH_DOT) k = K_RANGE;
    return k;
  endfunction

endpackage

### rtl/core/pst_if.sv
interface pst_in_if;
  logic                     valid;
  logic                     ready;
  logic [pst_pkg::BYTE_W-1:0] source_byte;
  logic                     end_of_input;
  modport source (output valid, source_byte, end_of_input, input ready);
  modport sink   (input valid, source_byte, end_of_input, output ready);
endinterface

interface pst_out_if;
  logic                       valid;
  logic                       ready;
  logic [pst_pkg::KIND_W-1:0] token_kind;
  logic [pst_pkg::LINE_W-1:0] token_line;
  logic [pst_pkg::COL_W-1:0]  token_column;
  logic [pst_pkg::NUM_W-1:0]  number_value;
  logic [pst_pkg::BYTE_W-1:0] text_byte;
  logic                       last_of_run;
  modport source (output valid, token_kind, token_line, token_column, number_value,
                  text_byte, last_of_run, input ready);
  modport sink   (input valid, token_kind, token_line, token_column, number_value,
                  text_byte, last_of_run, output ready);
endinterface

### rtl/core/pst_ctrl.sv
module pst_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  pst_pkg::pst_sts_t sts,
  output pst_pkg::pst_cmd_t cmd
);
  import pst_pkg::*;

  ctl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= C_READY;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt  = state_r;
    in_ready   = 1'b0;
    cmd        = '0;
    cmd.sel    = SEL_PRE;
    unique case (state_r)
      C_READY: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
        if (in_valid) state_nxt = C_DISPATCH;
      end
      C_DISPATCH: begin
        unique case (sts.pre)
          P_ONE:   state_nxt = C_PRE;
          P_TEXT:  state_nxt = C_TXT_RD;
          default: state_nxt = sts.post ? C_POST : C_READY;
        endcase
      end
      C_PRE: begin
        if (sts.out_free) begin
          cmd.load  = 1'b1;
          cmd.sel   = SEL_PRE;
          cmd.last  = !sts.post;
          state_nxt = sts.post ? C_POST : C_READY;
        end
      end
      // wait for the registered text read
      C_TXT_RD: state_nxt = C_TXT_OUT;
      C_TXT_OUT: begin
        if (sts.out_free) begin
          cmd.load = 1'b1;
          cmd.sel  = SEL_TXT;
          cmd.adv  = 1'b1;
          cmd.last = sts.idx_last && !sts.post;
          if (!sts.idx_last)  state_nxt = C_TXT_RD;
          else if (sts.post)  state_nxt = C_POST;
          else                state_nxt = C_READY;
        end
      end
      C_POST: begin
        if (sts.out_free) begin
          cmd.load  = 1'b1;
          cmd.sel   = SEL_POST;
          cmd.last  = 1'b1;
          state_nxt = C_READY;
        end
      end
      default: state_nxt = C_READY;
    endcase
  end

endmodule

### rtl/core/pst_dp.sv
module pst_dp (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [pst_pkg::BYTE_W-1:0] source_byte,
  input  logic                       end_of_input,
  input  pst_pkg::pst_cmd_t          cmd,
  output pst_pkg::pst_sts_t          sts,
  input  logic                       out_ready,
  output logic                       out_valid,
  output logic [pst_pkg::KIND_W-1:0] token_kind,
  output logic [pst_pkg::LINE_W-1:0] token_line,
  output logic [pst_pkg::COL_W-1:0]  token_column,
  output logic [pst_pkg::NUM_W-1:0]  number_value,
  output logic [pst_pkg::BYTE_W-1:0] text_byte,
  output logic                       last_of_run
);
  import pst_pkg::*;

  // lexer state
  lex_mode_t          mode_r, mode_nxt;
  logic [LINE_W-1:0]  line_r, line_nxt;
  logic [COL_W-1:0]   col_r, col_nxt;
  logic [COL_W-1:0]   scol_r, scol_nxt;
  logic [NUM_W-1:0]   acc_r, acc_nxt;
  logic [LEN_W-1:0]   tlen_r, tlen_nxt;
  logic [7:0]         pend_r, pend_nxt;
  logic               halted_r, halted_nxt;
  logic               kwb_r, kwb_nxt, kwe_r, kwe_nxt, kwp_r, kwp_nxt;

  // per-request emission plan
  pre_plan_t          pre_r, pre_nxt;
  logic               post_r, post_nxt;
  logic [LINE_W-1:0]  lineq_r;
  logic [KIND_W-1:0]  pre_kind_r, pre_kind_nxt, post_kind_r, post_kind_nxt;
  logic [COL_W-1:0]   pre_col_r, pre_col_nxt, post_col_r, post_col_nxt;
  logic [NUM_W-1:0]   pre_num_r, pre_num_nxt;
  logic [7:0]         pre_byte_r, pre_byte_nxt, post_byte_r, post_byte_nxt;
  logic [LEN_W-1:0]   idx_r;

  logic [7:0]         tmem [MAX_TEXT];
  logic [7:0]         rd_byte_r;
  logic               we;
  logic [TIDX_W-1:0]  waddr;

  logic               out_valid_r;
  logic [KIND_W-1:0]  kind_r;
  logic [LINE_W-1:0]  oline_r;
  logic [COL_W-1:0]   ocol_r;
  logic [NUM_W-1:0]   onum_r;
  logic [7:0]         obyte_r;
  logic               olast_r;

  logic [7:0]         b, lb;
  logic [KIND_W-1:0]  k1, k2, kpend;
  logic [COL_W-1:0]   col_inc;
  logic [LINE_W-1:0]  line_inc;
  logic [NUM_W+3:0]   acc_x10;
  logic               kw_hit_b, kw_hit_e, kw_hit_p, do_idle, full;

  assign b        = source_byte;
  assign lb       = to_lower(b);
  assign k1       = single_op(b);
  assign k2       = double_op(pend_r, b);
  assign kpend    = single_op(pend_r);
  assign col_inc  = (col_r == COL_MAX) ? col_r : col_r + 1'b1;
  assign line_inc = (line_r == LINE_MAX) ? line_r : line_r + 1'b1;
  assign acc_x10  = {acc_r, 3'b000} + {2'b00, acc_r, 1'b0} + {{(NUM_W){1'b0}}, b[3:0]};
  assign full     = (tlen_r >= LEN_W'(MAX_TEXT));
  assign kw_hit_b = kwb_r && (tlen_r == LEN_W'(5));
  assign kw_hit_e = kwe_r && (tlen_r == LEN_W'(3));
  assign kw_hit_p = kwp_r && (tlen_r == LEN_W'(7));

  always_comb begin
    mode_nxt = mode_r;  line_nxt = line_r;  col_nxt = col_r;  scol_nxt = scol_r;
    acc_nxt = acc_r;  tlen_nxt = tlen_r;  pend_nxt = pend_r;  halted_nxt = halted_r;
    kwb_nxt = kwb_r;  kwe_nxt = kwe_r;  kwp_nxt = kwp_r;
    pre_nxt = P_NONE;  post_nxt = 1'b0;
    pre_kind_nxt = K_INT;  pre_col_nxt = scol_r;  pre_num_nxt = '0;  pre_byte_nxt = '0;
    post_kind_nxt = K_EOF;  post_col_nxt = col_r;  post_byte_nxt = '0;
    we = 1'b0;  waddr = tlen_r[TIDX_W-1:0];
    do_idle = 1'b0;

    if (!halted_r) begin
      if (end_of_input) begin
        halted_nxt = 1'b1;
        mode_nxt   = M_IDLE;
        post_nxt   = 1'b1;
        unique case (mode_r)
          M_NUMBER: begin
            pre_nxt = P_ONE;  pre_kind_nxt = K_INT;  pre_num_nxt = acc_r;
          end
          M_IDENT: begin
            if (kw_hit_b || kw_hit_e || kw_hit_p) begin
              pre_nxt = P_ONE;
              pre_kind_nxt = kw_hit_b ? K_BEGIN : (kw_hit_e ? K_END : K_PROGRAM);
            end else begin
              pre_nxt = P_TEXT;  pre_kind_nxt = K_IDENT;  pre_num_nxt = NUM_W'(tlen_r);
            end
          end
          M_OP: begin
            pre_nxt = P_ONE;
            if (kpend != OP_NONE) pre_kind_nxt = kpend;
            else begin
              pre_kind_nxt = K_E_STRAY;  pre_byte_nxt = pend_r;  post_nxt = 1'b0;
            end
          end
          M_STRING: begin
            pre_nxt = P_ONE;  pre_kind_nxt = K_E_STR;  post_nxt = 1'b0;
          end
          M_BRACE, M_PAREN, M_PSTAR: begin
            pre_nxt = P_ONE;  pre_kind_nxt = K_E_CMT;  pre_col_nxt = col_r;
            post_nxt = 1'b0;
          end
          default: ;
        endcase
      end else begin
        unique case (mode_r)
          M_NUMBER: begin
            if (is_digit(b)) begin
              acc_nxt = (acc_x10 > {4'b0000, NUM_MAX}) ? NUM_MAX : acc_x10[NUM_W-1:0];
              col_nxt = col_inc;
            end else begin
              pre_nxt = P_ONE;  pre_kind_nxt = K_INT;  pre_num_nxt = acc_r;
              do_idle = 1'b1;
            end
          end
          M_IDENT: begin
            if (is_alpha(b) || is_digit(b)) begin
              if (full) begin
                pre_nxt = P_ONE;  pre_kind_nxt = K_E_LONG;  halted_nxt = 1'b1;
              end else begin
                we = 1'b1;  tlen_nxt = tlen_r + 1'b1;  col_nxt = col_inc;
                if (tlen_r < LEN_W'(5)) kwb_nxt = kwb_r && (lb == KW_BEGIN[tlen_r[2:0]]);
                if (tlen_r < LEN_W'(3)) kwe_nxt = kwe_r && (lb == KW_END[tlen_r[1:0]]);
                if (tlen_r < LEN_W'(7)) kwp_nxt = kwp_r && (lb == KW_PROG[tlen_r[2:0]]);
              end
            end else begin
              if (kw_hit_b || kw_hit_e || kw_hit_p) begin
                pre_nxt = P_ONE;
                pre_kind_nxt = kw_hit_b ? K_BEGIN : (kw_hit_e ? K_END : K_PROGRAM);
              end else begin
                pre_nxt = P_TEXT;  pre_kind_nxt = K_IDENT;  pre_num_nxt = NUM_W'(tlen_r);
              end
              do_idle = 1'b1;
            end
          end
          M_STRING: begin
            if (b == CH_QUOTE) begin
              pre_kind_nxt = K_STRING;
              pre_nxt = (tlen_r == '0) ? P_ONE : P_TEXT;
              pre_num_nxt = NUM_W'(tlen_r);
              col_nxt = col_inc;
              mode_nxt = M_IDLE;
            end else if (b == CH_LF) begin
              pre_nxt = P_ONE;  pre_kind_nxt = K_E_LF;  halted_nxt = 1'b1;
            end else if (full) begin
              pre_nxt = P_ONE;  pre_kind_nxt = K_E_LONG;  halted_nxt = 1'b1;
            end else begin
              we = 1'b1;  tlen_nxt = tlen_r + 1'b1;
              if (b != CH_CR) col_nxt = col_inc;
            end
          end
          M_BRACE, M_PAREN, M_PSTAR: begin
            if (mode_r == M_BRACE) begin
              if (b == CH_RBRACE) mode_nxt = M_IDLE;
            end else if (mode_r == M_PSTAR && b == CH_RPAREN) begin
              mode_nxt = M_IDLE;
            end else begin
              mode_nxt = (b == CH_STAR) ? M_PSTAR : M_PAREN;
            end
            if (b == CH_LF) begin
              line_nxt = line_inc;  col_nxt = COL_W'(1);
            end else if (b != CH_CR) begin
              col_nxt = col_inc;
            end
          end
          M_OP: begin
            if (k2 != OP_NONE) begin
              pre_nxt = P_ONE;  pre_kind_nxt = k2;  col_nxt = col_inc;  mode_nxt = M_IDLE;
            end else if (pend_r == CH_LPAREN && b == CH_STAR) begin
              mode_nxt = M_PAREN;  col_nxt = col_inc;
            end else begin
              pre_nxt = P_ONE;
              if (kpend != OP_NONE) begin
                pre_kind_nxt = kpend;  do_idle = 1'b1;
              end else begin
                pre_kind_nxt = K_E_STRAY;  pre_byte_nxt = pend_r;  halted_nxt = 1'b1;
              end
            end
          end
          default: do_idle = 1'b1;
        endcase

        if (do_idle) begin
          mode_nxt = M_IDLE;
          if (b == CH_LF) begin
            line_nxt = line_inc;  col_nxt = COL_W'(1);
          end else if (b == CH_CR) begin
            col_nxt = col_r;
          end else if (b == CH_SPACE || b == CH_TAB) begin
            col_nxt = col_inc;
          end else if (b == CH_LBRACE) begin
            mode_nxt = M_BRACE;  col_nxt = col_inc;
          end else if (is_digit(b)) begin
            acc_nxt = NUM_W'(b[3:0]);
            scol_nxt = col_r;  mode_nxt = M_NUMBER;  col_nxt = col_inc;
          end else if (is_alpha(b)) begin
            we = 1'b1;  waddr = '0;  tlen_nxt = LEN_W'(1);
            kwb_nxt = (lb == KW_BEGIN[0]);
            kwe_nxt = (lb == KW_END[0]);
            kwp_nxt = (lb == KW_PROG[0]);
            scol_nxt = col_r;  mode_nxt = M_IDENT;  col_nxt = col_inc;
          end else if (b == CH_QUOTE) begin
            tlen_nxt = '0;  scol_nxt = col_r;  mode_nxt = M_STRING;  col_nxt = col_inc;
          end else if (b == CH_LPAREN || b == CH_COLON || b == CH_LT || b == CH_GT ||
                       b == CH_DOT) begin
            pend_nxt = b;  scol_nxt = col_r;  mode_nxt = M_OP;  col_nxt = col_inc;
          end else if (k1 != OP_NONE) begin
            post_nxt = 1'b1;  post_kind_nxt = k1;  col_nxt = col_inc;
          end else begin
            post_nxt = 1'b1;  post_kind_nxt = K_E_STRAY;  post_byte_nxt = b;
            halted_nxt = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_IDLE;  line_r <= LINE_W'(1);  col_r <= COL_W'(1);  scol_r <= COL_W'(1);
      acc_r <= '0;  tlen_r <= '0;  pend_r <= '0;  halted_r <= 1'b0;
      kwb_r <= 1'b0;  kwe_r <= 1'b0;  kwp_r <= 1'b0;
      pre_r <= P_NONE;  post_r <= 1'b0;  idx_r <= '0;
    end else if (cmd.accept) begin
      mode_r <= mode_nxt;  line_r <= line_nxt;  col_r <= col_nxt;  scol_r <= scol_nxt;
      acc_r <= acc_nxt;  tlen_r <= tlen_nxt;  pend_r <= pend_nxt;  halted_r <= halted_nxt;
      kwb_r <= kwb_nxt;  kwe_r <= kwe_nxt;  kwp_r <= kwp_nxt;
      pre_r <= pre_nxt;  post_r <= post_nxt;  idx_r <= '0;
    end else if (cmd.adv) begin
      idx_r <= idx_r + 1'b1;
    end
  end

  // plan payload, captured with the request
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      lineq_r <= line_r;
      pre_kind_r <= pre_kind_nxt;  pre_col_r <= pre_col_nxt;
      pre_num_r <= pre_num_nxt;  pre_byte_r <= pre_byte_nxt;
      post_kind_r <= post_kind_nxt;  post_col_r <= post_col_nxt;
      post_byte_r <= post_byte_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && we) tmem[waddr] <= b;
    rd_byte_r <= tmem[idx_r[TIDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n)          out_valid_r <= 1'b0;
    else if (cmd.load)   out_valid_r <= 1'b1;
    else if (out_ready)  out_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      oline_r <= lineq_r;
      olast_r <= cmd.last;
      unique case (cmd.sel)
        SEL_TXT: begin
          kind_r <= pre_kind_r;  ocol_r <= pre_col_r;  onum_r <= pre_num_r;
          obyte_r <= rd_byte_r;
        end
        SEL_POST: begin
          kind_r <= post_kind_r;  ocol_r <= post_col_r;  onum_r <= '0;
          obyte_r <= post_byte_r;
        end
        default: begin
          kind_r <= pre_kind_r;  ocol_r <= pre_col_r;  onum_r <= pre_num_r;
          obyte_r <= pre_byte_r;
        end
      endcase
    end
  end

  assign sts.pre      = pre_r;
  assign sts.post     = post_r;
  assign sts.idx_last = (idx_r == pre_num_r[LEN_W-1:0] - 1'b1);
  assign sts.out_free = !out_valid_r || out_ready;
  assign sts.halted   = halted_r;

  assign out_valid    = out_valid_r;
  assign token_kind   = kind_r;
  assign token_line   = oline_r;
  assign token_column = ocol_r;
  assign number_value = onum_r;
  assign text_byte    = obyte_r;
  assign last_of_run  = olast_r;

endmodule

### rtl/core/pascal_subset_tokenizer_core.sv
// Flow: a request is accepted in C_READY and decoded in C_DISPATCH. A request with no result
// then returns to C_READY; a single result is loaded into the output register from C_PRE or
// C_POST, and identifier or string text one byte at a time through C_TXT_RD and C_TXT_OUT,
// as the text store has a registered read port. Each load waits while the output register
// holds a token that has not been taken. One request is in work at a time.
// Reset (rst_n low, synchronous): line and column to one, lexer idle, output empty.
`include "pascal_subset_tokenizer_core_macros.svh"

module pascal_subset_tokenizer_core (
  input  logic      clk,
  input  logic      rst_n,
  pst_in_if.sink    in_ch,
  pst_out_if.source out_ch
);
  import pst_pkg::*;

  pst_cmd_t cmd;
  pst_sts_t sts;

  pst_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  pst_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .source_byte  (in_ch.source_byte),
    .end_of_input (in_ch.end_of_input),
    .cmd          (cmd),
    .sts          (sts),
    .out_ready    (out_ch.ready),
    .out_valid    (out_ch.valid),
    .token_kind   (out_ch.token_kind),
    .token_line   (out_ch.token_line),
    .token_column (out_ch.token_column),
    .number_value (out_ch.number_value),
    .text_byte    (out_ch.text_byte),
    .last_of_run  (out_ch.last_of_run)
  );

  `PST_ASSERT_IMPLY(a_load_into_free, cmd.load, sts.out_free)
  `PST_ASSERT_NEXT(a_one_request, in_ch.valid && in_ch.ready, !in_ch.ready)
  `PST_ASSERT_NEXT(a_halt_sticky, sts.halted, sts.halted)

endmodule
